// ----- design/assert_macros.svh -----
// Assertion macros shared by the SM3 RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ----- design/sm3_pkg.sv -----
// Package for the SM3 hash core: payload structs, constants, round functions.
// No dependencies.
package sm3_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last_item;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic [255:0] IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };
    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // control handed from the top level to the compression unit
    typedef struct packed {
        logic        start;
        logic [511:0] block;
    } cmp_ctl_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ----- design/sm3_compress.sv -----
// SM3 compression unit: one round per cycle, 16-word sliding expansion window.
// Depends on sm3_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sm3_compress (
    input  logic              clk,
    input  logic              rst_n,
    input  sm3_pkg::cmp_ctl_t ctl,
    input  logic [255:0]      cv_in,
    output logic [255:0]      cv_out,
    output logic              busy,
    output logic              done
);
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [255:0] v_reg, v_next, cv_reg, cv_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next, done_reg, done_next;

    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, s1, s2, ff, gg, t1, t2, wnew;
    logic [5:0]  rnd_inc;

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = v_reg;
        tj   = (rnd_reg < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
        a12  = sm3_pkg::rotl(a, 5'd12);
        s1   = sm3_pkg::rotl(a12 + e + sm3_pkg::rotl(tj, rnd_reg[4:0]), 5'd7);
        s2   = s1 ^ a12;
        if (rnd_reg < 6'd16)
        begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
        end
        else
        begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
        end
        t1   = ff + d + s2 + (w_reg[0] ^ w_reg[4]);
        t2   = gg + h + s1 + w_reg[0];
        // next expansion word W[j+16]
        wnew = sm3_pkg::p1(w_reg[0] ^ w_reg[7] ^ sm3_pkg::rotl(w_reg[13], 5'd15))
             ^ sm3_pkg::rotl(w_reg[3], 5'd7) ^ w_reg[10];
        rnd_inc = rnd_reg + 6'd1;

        w_next    = w_reg;
        v_next    = v_reg;
        cv_next   = cv_reg;
        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start && !busy_reg)
        begin
            for (int i = 0; i < 16; i++)
                w_next[i] = ctl.block[511 - 32*i -: 32];
            v_next    = cv_in;
            cv_next   = cv_in;
            rnd_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i+1];
            w_next[15] = wnew;
            v_next = {t1, a, sm3_pkg::rotl(b, 5'd9), c,
                      sm3_pkg::p0(t2), e, sm3_pkg::rotl(f, 5'd19), g};
            rnd_next = rnd_inc;
            if (rnd_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cv_next   = cv_reg ^ v_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rnd_reg  <= rnd_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg  <= w_next;
        v_reg  <= v_next;
        cv_reg <= cv_next;
    end

    assign cv_out = cv_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;

    `ASSERT_NEXT(a_done_after_last, clk, rst_n, busy_reg && rnd_reg == 6'd63, done_reg && !busy_reg)
    `ASSERT_IMPLY(a_done_not_busy, clk, rst_n, done_reg, !busy_reg)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, ctl.start && !busy_reg, busy_reg && rnd_reg == 6'd0)
endmodule

// ----- design/sm3_hash_core.sv -----
// SM3 hash engine top level.
// Depends on sm3_pkg, sm3_compress and assert_macros.svh.
//
// Usage: message bytes enter on in_valid/in_ready as items of one 32-bit
// big-endian word with a byte count (full words except on the last item).
// in_ready is high only in the idle state. After the 16th word of a block
// ready drops while ST_CMP starts the shared round unit, the unit runs its
// rounds one a cycle and ST_WAIT takes the result.
// On the last item the block is padded (0x80, zeros, 64-bit bit length)
// one word a cycle, one or two more blocks are compressed, and eight digest
// items leave on out_valid/out_ready, word 0 most significant, last_word on 7.
// The digest is read straight from the chaining value register: a stalled
// receiver holds the engine in its output state, with in_ready low, until
// all eight words are taken; no item is lost.
// After the last block the words go out one a cycle while out_ready is high.
// Reset (rst_n low, asynchronous) restores the initial vector and clears
// the fill count and length; the same happens after each digest.
`include "assert_macros.svh"
module sm3_hash_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sm3_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sm3_pkg::out_item_t   out_data
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,   // writing pad / length words one per cycle
        ST_CMP  = 5'b00100,   // starting the round unit
        ST_WAIT = 5'b01000,   // waiting for the round unit to finish
        ST_OUT  = 5'b10000
    } state_t;

    state_t       state_reg, state_next;
    logic [31:0]  buf_reg [16];
    logic [31:0]  buf_next [16];
    logic [3:0]   fill_reg, fill_next;
    logic [63:0]  len_reg, len_next;
    logic [255:0] cv_reg, cv_next;
    logic         fin_reg, fin_next;     // padding phase of the last item
    logic         lenw_reg, lenw_next;   // length words written
    logic [2:0]   oidx_reg, oidx_next;

    sm3_pkg::cmp_ctl_t ctl;
    logic [255:0] cmp_cv;
    logic         cmp_busy, cmp_done;

    logic [2:0]  nb;
    logic [31:0] keep, padw;
    logic [63:0] len_add;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            ctl.block[511 - 32*i -: 32] = buf_reg[i];
        ctl.start = (state_reg == ST_CMP) && !cmp_busy;
    end

    sm3_compress u_cmp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cv_in  (cv_reg),
        .cv_out (cmp_cv),
        .busy   (cmp_busy),
        .done   (cmp_done)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data.digest_word = cv_reg[255 - 32*oidx_reg -: 32];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = (oidx_reg == 3'd7);

    always_comb
    begin
        nb = (!in_data.last_item || in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
        case (nb)
            3'd0:    keep = 32'h0000_0000;
            3'd1:    keep = 32'hFF00_0000;
            3'd2:    keep = 32'hFFFF_0000;
            3'd3:    keep = 32'hFFFF_FF00;
            default: keep = 32'hFFFF_FFFF;
        endcase
        padw    = (in_data.message_word & keep)
                | ({24'd0, sm3_pkg::PAD_BYTE} << (5'd24 - {nb[1:0], 3'd0}));
        len_add = len_reg + {58'd0, nb, 3'd0};

        state_next = state_reg;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        cv_next    = cv_reg;
        fin_next   = fin_reg;
        lenw_next  = lenw_reg;
        oidx_next  = oidx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    len_next = len_add;
                    if (in_data.last_item && nb != 3'd4)
                        buf_next[fill_reg] = padw;
                    else
                        buf_next[fill_reg] = in_data.message_word;
                    fill_next = fill_reg + 4'd1;
                    if (in_data.last_item)
                    begin
                        fin_next  = 1'b1;
                        lenw_next = 1'b0;
                        if (nb == 3'd4)
                        begin
                            if (fill_reg == 4'd15)
                                state_next = ST_CMP;
                            else
                                state_next = ST_PAD;
                            // 0x80 word still owed: mark by full pad word below
                        end
                        else
                            state_next = (fill_reg == 4'd15) ? ST_CMP : ST_PAD;
                    end
                    else if (fill_reg == 4'd15)
                        state_next = ST_CMP;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 4'd14 && !lenw_reg)
                begin
                    buf_next[14] = len_reg[63:32];
                    buf_next[15] = len_reg[31:0];
                    lenw_next    = 1'b1;
                    fill_next    = 4'd0;
                    state_next   = ST_CMP;
                end
                else
                begin
                    buf_next[fill_reg] = 32'd0;
                    fill_next = fill_reg + 4'd1;
                    if (fill_reg == 4'd15)
                        state_next = ST_CMP;
                end
            end
            ST_CMP:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (cmp_done)
                begin
                    cv_next   = cmp_cv;
                    fill_next = 4'd0;
                    if (!fin_reg)
                        state_next = ST_IDLE;
                    else if (lenw_reg)
                    begin
                        state_next = ST_OUT;
                        oidx_next  = 3'd0;
                    end
                    else
                        state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        cv_next    = sm3_pkg::IV;
                        len_next   = '0;
                        fin_next   = 1'b0;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // A full last word owes a separate 0x80 word; it is inserted on the first
    // pad cycle (or after the block closed by that word compresses).
    logic owe_reg, owe_next;
    always_comb
    begin
        owe_next = owe_reg;
        if (state_reg == ST_IDLE && in_valid && in_data.last_item)
            owe_next = (nb == 3'd4);
        else if (state_reg == ST_PAD && owe_reg)
            owe_next = 1'b0;
    end

    // The owed 0x80 also covers the case where it lands at word 14 and
    // replaces the length word written there by the state machine.
    logic [31:0] buf_fin [16];
    always_comb
    begin
        buf_fin = buf_next;
        if (state_reg == ST_PAD && owe_reg)
            buf_fin[fill_reg] = 32'h8000_0000;
    end

    logic pad_len_ok;
    assign pad_len_ok = !(state_reg == ST_PAD && owe_reg && fill_reg == 4'd14);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            cv_reg    <= sm3_pkg::IV;
            fin_reg   <= 1'b0;
            lenw_reg  <= 1'b0;
            oidx_reg  <= '0;
            owe_reg   <= 1'b0;
        end
        else
        begin
            owe_reg  <= owe_next;
            len_reg  <= len_next;
            cv_reg   <= cv_next;
            fin_reg  <= fin_next;
            oidx_reg <= oidx_next;
            if (pad_len_ok)
            begin
                state_reg <= state_next;
                fill_reg  <= fill_next;
                lenw_reg  <= lenw_next;
            end
            else
            begin
                // 0x80 lands at word 14: word 15 is zeroed, the length goes to the next block
                state_reg <= ST_PAD;
                fill_reg  <= 4'd15;
                lenw_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_fin;
    end

    `ASSERT_IMPLY(a_ready_idle, clk, rst_n, in_ready, !out_valid && !cmp_busy)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(oidx_reg))
    `ASSERT_IMPLY(a_done_in_wait, clk, rst_n, cmp_done, state_reg == ST_WAIT)
endmodule
